### sv/two_stack_binary_radix_sort_defines.svh
// ----------------------------------------------------------------------------
// Two-stack binary radix sorter: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_BINARY_RADIX_SORT_DEFINES_SVH
`define TWO_STACK_BINARY_RADIX_SORT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TSRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define TSRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tsrs_pkg.sv
// ----------------------------------------------------------------------------
// Two-stack binary radix sorter: package
// Item types of both channels and default sizes.
// ----------------------------------------------------------------------------
package tsrs_pkg;

  localparam int unsigned DEFAULT_MAX_ITEMS  = 64;
  localparam int unsigned DEFAULT_VALUE_BITS = 32;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_res;
    logic               dropped;
  } out_item_t;

endpackage

### sv/tsrs_front.sv
// ----------------------------------------------------------------------------
// Two-stack binary radix sorter: front end
// Accepts input items, trims each value to its stored width and queues it
// with its last marker for the sorting engine.
// ----------------------------------------------------------------------------
module tsrs_front import tsrs_pkg::*; #(
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output logic [VALUE_BITS-1:0] q_value_o,
  output logic                  q_last_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PW     = $clog2(QDepth);
  localparam int unsigned FW     = $clog2(QDepth + 1);

  logic [VALUE_BITS-1:0] val_mem [QDepth];
  logic                  last_mem [QDepth];
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic                  push, pop;

  assign in_ready_o = (fill_q != FW'(QDepth));
  assign q_valid_o  = (fill_q != '0);
  assign q_value_o  = val_mem[rd_ptr_q];
  assign q_last_o   = last_mem[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    fill_d   = fill_q + FW'(push) - FW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      val_mem[wr_ptr_q]  <= in_data_i.value[VALUE_BITS-1:0];
      last_mem[wr_ptr_q] <= in_data_i.last;
    end
  end

endmodule

### sv/tsrs_back.sv
// ----------------------------------------------------------------------------
// Two-stack binary radix sorter: sorting engine
// Stores the list, runs the order check and the radix passes over two
// ping-pong memories, and emits the sorted list through an output register.
// ----------------------------------------------------------------------------
module tsrs_back import tsrs_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = DEFAULT_MAX_ITEMS,
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  logic [VALUE_BITS-1:0] q_value_i,
  input  logic                  q_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned BW = $clog2(VALUE_BITS + 1);
  localparam int unsigned XW = $clog2(VALUE_BITS);

  localparam logic [2:0] ST_LOAD      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_PASS      = 3'd2;
  localparam logic [2:0] ST_EMIT_RD   = 3'd3;
  localparam logic [2:0] ST_EMIT_LD   = 3'd4;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic                  sel_q, sel_d;
  logic [CW-1:0]         iss_q, iss_d, proc_q, proc_d;
  logic                  rvalid_q, rvalid_d;
  logic                  asc_q, asc_d;
  logic [CW-1:0]         mcnt_q, mcnt_d;
  logic [VALUE_BITS-1:0] prev_q, prev_d;
  logic [CW-1:0]         mv_q, mv_d, st_q, st_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  // Two memories; the one named by sel_q holds the current list.
  logic [VALUE_BITS-1:0] mem_a [MAX_ITEMS];
  logic [VALUE_BITS-1:0] mem_b [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rd_a_q, rd_b_q, rd_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  ld_we, ps_we;
  logic [AW-1:0]         ld_addr, ps_addr;
  logic                  we_a, we_b;
  logic [AW-1:0]         wa_a, wa_b;
  logic [VALUE_BITS-1:0] wd_a, wd_b;

  logic                  bit_val, is_sign, moves, violation, proc_last;
  logic [CW-1:0]         mcnt_nx;

  assign rd_data   = sel_q ? rd_b_q : rd_a_q;
  assign bit_val   = rd_data[bit_q[XW-1:0]];
  assign is_sign   = (bit_q == BW'(VALUE_BITS - 1));
  assign moves     = is_sign ? bit_val : !bit_val;
  assign violation = (proc_q != '0) && ($signed(prev_q) > $signed(rd_data));
  assign proc_last = (proc_q == cnt_q - CW'(1));
  assign mcnt_nx   = mcnt_q + CW'(moves);

  assign q_ready_o   = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    bit_d       = bit_q;
    sel_d       = sel_q;
    iss_d       = iss_q;
    proc_d      = proc_q;
    rvalid_d    = 1'b0;
    asc_d       = asc_q;
    mcnt_d      = mcnt_q;
    prev_d      = prev_q;
    mv_d        = mv_q;
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = iss_q[AW-1:0];
    ld_we       = 1'b0;
    ld_addr     = cnt_q[AW-1:0];
    ps_we       = 1'b0;
    ps_addr     = mv_q[AW-1:0];

    unique case (state_q)
      ST_LOAD: begin
        if (q_valid_i) begin
          if (cnt_q < CW'(MAX_ITEMS)) begin
            ld_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (q_last_i) begin
            state_d = ST_SCAN;
            bit_d   = '0;
            iss_d   = '0;
            proc_d  = '0;
            asc_d   = 1'b1;
            mcnt_d  = '0;
          end
        end
      end

      ST_SCAN, ST_PASS: begin
        // Reads are issued one per cycle; the data returns in the following cycle.
        if (iss_q < cnt_q) begin
          rd_en    = 1'b1;
          iss_d    = iss_q + CW'(1);
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          proc_d = proc_q + CW'(1);
          if (state_q == ST_SCAN) begin
            prev_d = rd_data;
            mcnt_d = mcnt_nx;
            if (violation) begin
              asc_d = 1'b0;
            end
            if (proc_last) begin
              proc_d = '0;
              iss_d  = '0;
              if ((asc_q && !violation) || (bit_q == BW'(VALUE_BITS))) begin
                state_d = ST_EMIT_RD;
              end else begin
                state_d = ST_PASS;
                mv_d    = '0;
                st_d    = mcnt_nx;
              end
            end
          end else begin
            // Moved items fill the front of the other memory, kept items
            // follow them, both in their original order.
            ps_we = 1'b1;
            if (moves) begin
              ps_addr = mv_q[AW-1:0];
              mv_d    = mv_q + CW'(1);
            end else begin
              ps_addr = st_q[AW-1:0];
              st_d    = st_q + CW'(1);
            end
            if (proc_last) begin
              state_d = ST_SCAN;
              sel_d   = !sel_q;
              bit_d   = bit_q + BW'(1);
              proc_d  = '0;
              iss_d   = '0;
              asc_d   = 1'b1;
              mcnt_d  = '0;
            end
          end
        end
      end

      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = proc_q[AW-1:0];
        state_d = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_d.sorted_value = 32'($signed(rd_data));
        out_d.last_res     = proc_last;
        out_d.dropped      = proc_last && ovf_q;
        out_valid_d        = 1'b1;
        state_d            = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_q.last_res) begin
            state_d = ST_LOAD;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            bit_d   = '0;
            proc_d  = '0;
          end else begin
            proc_d  = proc_q + CW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      bit_q       <= '0;
      sel_q       <= 1'b0;
      iss_q       <= '0;
      proc_q      <= '0;
      rvalid_q    <= 1'b0;
      asc_q       <= 1'b1;
      mcnt_q      <= '0;
      mv_q        <= '0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      bit_q       <= bit_d;
      sel_q       <= sel_d;
      iss_q       <= iss_d;
      proc_q      <= proc_d;
      rvalid_q    <= rvalid_d;
      asc_q       <= asc_d;
      mcnt_q      <= mcnt_d;
      mv_q        <= mv_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    out_q  <= out_d;
  end

  // Loading writes the current memory, a pass writes the other one.
  assign we_a = (ld_we && !sel_q) || (ps_we && sel_q);
  assign we_b = (ld_we && sel_q) || (ps_we && !sel_q);
  assign wa_a = sel_q ? ps_addr : ld_addr;
  assign wa_b = sel_q ? ld_addr : ps_addr;
  assign wd_a = sel_q ? rd_data : q_value_i;
  assign wd_b = sel_q ? q_value_i : rd_data;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wa_b] <= wd_b;
    end
    if (rd_en) begin
      rd_b_q <= mem_b[rd_addr];
    end
  end

endmodule

### sv/two_stack_binary_radix_sort.sv
// Sorts lists of signed values ascending. Values enter one per item and are
// stored until an item marked last; the list then goes through an order
// check and least-significant-bit-first binary radix passes, and is emitted
// one result per stored value, last_res marking the final one. An input
// queue of four entries keeps accepting items while the engine is busy.
// Each order check and each radix pass streams the list once through a
// memory read port, and a list needs at most VALUE_BITS passes, each
// followed by a check. Each result is read, loaded into the output
// register and held until it is taken before the next one is read.
// Values beyond MAX_ITEMS are discarded and reported by dropped on the
// final result.
// ----------------------------------------------------------------------------
// Two-stack binary radix sorter: top level
// Front end with input queue, followed by the sorting engine.
// ----------------------------------------------------------------------------
module two_stack_binary_radix_sort import tsrs_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = DEFAULT_MAX_ITEMS,
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic                  q_valid, q_ready, q_last;
  logic [VALUE_BITS-1:0] q_value;

  tsrs_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_value_o (q_value),
    .q_last_o  (q_last)
  );

  tsrs_back #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_value_i  (q_value),
    .q_last_i   (q_last),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### sv/tsrs_checker.sv
// ----------------------------------------------------------------------------
// Two-stack binary radix sorter: port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "two_stack_binary_radix_sort_defines.svh"

module tsrs_checker import tsrs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A stalled result keeps its item.
  `TSRS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Only the final result of a list may report discarded items.
  `TSRS_ASSERT(a_drop_on_last, !out_valid_o || out_data_o.last_res || !out_data_o.dropped, "dropped set on a result that is not last")

  // A new list must be loaded before anything follows the final result.
  `TSRS_ASSERT_NEXT(a_gap_after_last, out_valid_o && out_ready_i && out_data_o.last_res, !out_valid_o, "result right after the final result")

endmodule

bind two_stack_binary_radix_sort tsrs_checker u_tsrs_checker (.*);
